// File: sv/rmv_pkg.sv
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared types and constants for the running mean and variance core.
// ----------------------------------------------------------------------------
package rmv_pkg;

   // sample handling
   localparam int SAMPLE_BITS  = 16;
   localparam int SAMPLE_SHIFT = 16 - SAMPLE_BITS;
   localparam logic [15:0] MAX_COUNT = 16'd65535;

   // shared serial unit geometry
   localparam int WORD_BITS = 64;
   localparam int MAG_BITS  = 34;
   localparam int LEAD_PAD  = WORD_BITS - MAG_BITS;
   localparam int STEP_BITS = 7;

   localparam logic [STEP_BITS-1:0] DIV_MEAN_STEPS = STEP_BITS'(MAG_BITS);
   localparam logic [STEP_BITS-1:0] MUL_STEPS      = STEP_BITS'(MAG_BITS);
   localparam logic [STEP_BITS-1:0] DIV_VAR_STEPS  = STEP_BITS'(WORD_BITS);

   typedef enum logic [0:0] {
      OP_DIV = 1'b0,
      OP_MUL = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_FIRST     = 2'd0,
      STATUS_VALID     = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               restart;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        count;
      logic signed [31:0] mean;
      logic [47:0]        variance;
   } rsp_payload_type;

   // command into the shared unit
   typedef struct packed {
      logic                 start;
      op_type               op;
      logic [STEP_BITS-1:0] steps;
      logic [WORD_BITS-1:0] shreg;    // dividend or multiplier, left aligned
      logic [MAG_BITS-1:0]  operand;  // multiplicand, or divisor in low 16 bits
   } cmd_type;

   // status out of the shared unit
   typedef struct packed {
      logic done;
   } unit_stat_type;

endpackage

// File: sv/rmv_shared_unit.sv
// ----------------------------------------------------------------------------
// rmv_shared_unit
// Bit-serial shift-subtract divider and shift-add multiplier, one bit a cycle.
// ----------------------------------------------------------------------------
module rmv_shared_unit import rmv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output unit_stat_type        stat,
   output logic [WORD_BITS-1:0] result
);

   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   op_type               op_ff, op_in;
   logic [WORD_BITS-1:0] shreg_ff, shreg_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [15:0]          rem_ff, rem_in;
   logic [MAG_BITS-1:0]  operand_ff, operand_in;

   logic [16:0]          trial;
   logic [16:0]          diff;
   logic                 fits;
   logic [WORD_BITS-1:0] addend;
   logic [WORD_BITS-1:0] acc_step;

   // one division or multiplication step
   assign trial    = {rem_ff, shreg_ff[WORD_BITS-1]};
   assign diff     = trial - {1'b0, operand_ff[15:0]};
   assign fits     = trial >= {1'b0, operand_ff[15:0]};
   assign addend   = shreg_ff[WORD_BITS-1] ? {{LEAD_PAD{1'b0}}, operand_ff} : '0;
   assign acc_step = {acc_ff[WORD_BITS-2:0], 1'b0} + addend;

   always_comb begin
      cnt_in     = cnt_ff;
      op_in      = op_ff;
      shreg_in   = shreg_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      operand_in = operand_ff;
      done_in    = 1'b0;
      if (cmd.start) begin
         cnt_in     = cmd.steps;
         op_in      = cmd.op;
         shreg_in   = cmd.shreg;
         operand_in = cmd.operand;
         acc_in     = '0;
         rem_in     = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == STEP_BITS'(1));
         if (op_ff == OP_DIV) begin
            shreg_in = {shreg_ff[WORD_BITS-2:0], fits};
            rem_in   = fits ? diff[15:0] : trial[15:0];
         end else begin
            shreg_in = {shreg_ff[WORD_BITS-2:0], 1'b0};
            acc_in   = acc_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      op_ff      <= op_in;
      shreg_ff   <= shreg_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      operand_ff <= operand_in;
   end

   assign stat.done = done_ff;
   assign result    = (op_ff == OP_DIV) ? shreg_ff : acc_ff;

endmodule

// File: sv/running_mean_variance_core.sv
// ----------------------------------------------------------------------------
// running_mean_variance_core
// Welford online mean and sample variance over signed samples.
// ----------------------------------------------------------------------------
// Each accepted sample updates a running count, a Q16.16 mean and a Q.16 sum
// of squared deviations, and produces one result transfer with the status,
// count, mean and sample variance. All divisions and products run through
// one bit-serial unit that divides or multiplies one bit per cycle. A
// normal sample runs the mean division by n, the deviation product and the
// variance division by n-1, with prep states between them and a finish
// state at the end. A first sample (or restart) goes straight to the finish
// state, and a sample arriving once the count has saturated runs the
// variance division only. The input is stalled while a sample is in
// progress; a finished result sits in an output register, so the next
// sample can be taken while it waits.
// ----------------------------------------------------------------------------
module running_mean_variance_core import rmv_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DIV_MEAN = 7'b0000010,
      S_MUL_PREP = 7'b0000100,
      S_MUL      = 7'b0001000,
      S_VAR_PREP = 7'b0010000,
      S_DIV_VAR  = 7'b0100000,
      S_FINISH   = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [15:0]            count_ff, count_in;
   logic signed [32:0]     mean_ff, mean_in;
   logic [63:0]            sum_ff, sum_in;
   logic signed [31:0]     xq_ff, xq_in;
   logic                   a_neg_ff, a_neg_in;
   logic [MAG_BITS-1:0]    mag_a_ff, mag_a_in;
   status_type             status_ff, status_in;
   logic [47:0]            var_ff, var_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_ff, rsp_in;

   cmd_type                cmd;
   unit_stat_type          unit_stat;
   logic [WORD_BITS-1:0]   unit_result;

   logic                   accept;
   logic [15:0]            samp_shl;
   logic signed [15:0]     x16;
   logic signed [31:0]     req_xq;
   logic [33:0]            req_a;
   logic [MAG_BITS-1:0]    req_mag_a;
   logic [15:0]            count_inc;
   logic [34:0]            q_signed;
   logic [34:0]            nm_wide;
   logic [32:0]            nm_clamp;
   logic [33:0]            b_diff;
   logic                   opposite;
   logic [MAG_BITS-1:0]    mag_b;
   logic [64:0]            sum_wide;
   logic [63:0]            sum_sat;
   logic [47:0]            var_clamp;
   logic [31:0]            mean_out;

   // sample: low SAMPLE_BITS bits, sign extended, then moved to Q16.16
   assign samp_shl  = req_payload.sample << SAMPLE_SHIFT;
   assign x16       = $signed(samp_shl) >>> SAMPLE_SHIFT;
   assign req_xq    = {x16, 16'h0000};

   // deviation from the old mean
   assign req_a     = {{2{req_xq[31]}}, req_xq} - {mean_ff[32], mean_ff};
   assign req_mag_a = req_a[33] ? (34'd0 - req_a) : req_a;
   assign count_inc = count_ff + 16'd1;

   // mean update: signed quotient, then clamp to the 33-bit range
   assign q_signed  = a_neg_ff ? (35'd0 - {1'b0, unit_result[MAG_BITS-1:0]})
                               : {1'b0, unit_result[MAG_BITS-1:0]};
   assign nm_wide   = {{2{mean_ff[32]}}, mean_ff} + q_signed;

   always_comb begin
      if (!nm_wide[34] && nm_wide[33:32] != 2'b00) begin
         nm_clamp = {1'b0, 32'hFFFF_FFFF};
      end else if (nm_wide[34] && nm_wide[33:32] != 2'b11) begin
         nm_clamp = {1'b1, 32'h0000_0000};
      end else begin
         nm_clamp = nm_wide[32:0];
      end
   end

   // deviation from the new mean; opposite signs give a zero increment
   assign b_diff    = {{2{xq_ff[31]}}, xq_ff} - {mean_ff[32], mean_ff};
   assign opposite  = (a_neg_ff && !b_diff[33] && b_diff != '0) ||
                      (!a_neg_ff && mag_a_ff != '0 && b_diff[33]);
   assign mag_b     = opposite ? '0 : (b_diff[33] ? (34'd0 - b_diff) : b_diff);

   // sum of squares, saturating at all ones
   assign sum_wide  = {1'b0, sum_ff} + {17'd0, unit_result[63:16]};
   assign sum_sat   = sum_wide[64] ? '1 : sum_wide[63:0];

   // variance clamp to 48 bits
   assign var_clamp = (unit_result[63:48] != '0) ? '1 : unit_result[47:0];

   // output mean clamp to 32 bits
   always_comb begin
      if (mean_ff[32] != mean_ff[31]) begin
         mean_out = mean_ff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         mean_out = mean_ff[31:0];
      end
   end

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mean_in      = mean_ff;
      sum_in       = sum_ff;
      xq_in        = xq_ff;
      a_neg_in     = a_neg_ff;
      mag_a_in     = mag_a_ff;
      status_in    = status_ff;
      var_in       = var_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.op       = OP_DIV;

      // result register drains on a transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               xq_in = req_xq;
               if (req_payload.restart || count_ff == '0) begin
                  // first sample of a set
                  count_in  = 16'd1;
                  mean_in   = {req_xq[31], req_xq};
                  sum_in    = '0;
                  status_in = STATUS_FIRST;
                  var_in    = '0;
                  state_in  = S_FINISH;
               end else if (count_ff >= MAX_COUNT) begin
                  // saturated: state held, report held variance
                  status_in = STATUS_SATURATED;
                  state_in  = S_VAR_PREP;
               end else begin
                  count_in    = count_inc;
                  a_neg_in    = req_a[33];
                  mag_a_in    = req_mag_a;
                  status_in   = STATUS_VALID;
                  cmd.start   = 1'b1;
                  cmd.op      = OP_DIV;
                  cmd.steps   = DIV_MEAN_STEPS;
                  cmd.shreg   = {req_mag_a, {LEAD_PAD{1'b0}}};
                  cmd.operand = {{(MAG_BITS-16){1'b0}}, count_inc};
                  state_in    = S_DIV_MEAN;
               end
            end
         end
         S_DIV_MEAN: begin
            if (unit_stat.done) begin
               mean_in  = nm_clamp;
               state_in = S_MUL_PREP;
            end
         end
         S_MUL_PREP: begin
            cmd.start   = 1'b1;
            cmd.op      = OP_MUL;
            cmd.steps   = MUL_STEPS;
            cmd.shreg   = {mag_a_ff, {LEAD_PAD{1'b0}}};
            cmd.operand = mag_b;
            state_in    = S_MUL;
         end
         S_MUL: begin
            if (unit_stat.done) begin
               sum_in   = sum_sat;
               state_in = S_VAR_PREP;
            end
         end
         S_VAR_PREP: begin
            cmd.start   = 1'b1;
            cmd.op      = OP_DIV;
            cmd.steps   = DIV_VAR_STEPS;
            cmd.shreg   = sum_ff;
            cmd.operand = {{(MAG_BITS-16){1'b0}}, count_ff - 16'd1};
            state_in    = S_DIV_VAR;
         end
         S_DIV_VAR: begin
            if (unit_stat.done) begin
               var_in   = var_clamp;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // load the result register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status   = status_ff;
               rsp_in.count    = count_ff;
               rsp_in.mean     = mean_out;
               rsp_in.variance = var_ff;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mean_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      xq_ff     <= xq_in;
      a_neg_ff  <= a_neg_in;
      mag_a_ff  <= mag_a_in;
      status_ff <= status_in;
      var_ff    <= var_in;
      rsp_ff    <= rsp_in;
   end

   // shared serial divide / multiply unit
   rmv_shared_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .stat   (unit_stat),
      .result (unit_result)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
